FILE: rtl/gift_wrapping_convex_hull_unit_assert.svh
// Assertion macros shared by the convex hull unit modules
`ifndef GIFT_WRAPPING_CONVEX_HULL_UNIT_ASSERT_SVH
`define GIFT_WRAPPING_CONVEX_HULL_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HULL_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("convex hull unit: implication check failed");
`define HULL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("convex hull unit: next-cycle check failed");
`else
`define HULL_ASSERT_IMP(label, ante, cons)
`define HULL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/gwch_pkg.sv
// Types and constants shared by the convex hull unit
`timescale 1ns / 1ps
package gwch_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;

   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic [CNT_BITS-1:0]          cnt_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type px;
      coord_type py;
      logic      final_point;
   } req_type;

   typedef struct packed {
      coord_type hull_x;
      coord_type hull_y;
      logic      final_vertex;
      logic      cut_short;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      logic      en;
      idx_type   addr;
      point_type data;
   } mem_wr_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

endpackage

FILE: rtl/gift_wrapping_convex_hull_unit.sv
// Convex hull unit: top level with point store, sequencer and result register
//
// Points enter one per cycle while the unit is loading; the point marked final
// closes the set (at most 64 points are kept, later ones are dropped). The unit
// then walks the hull with gift wrapping and returns one result per hull vertex
// in walk order, starting at the first point of least x. The single read port
// of the point store sets the pace: the start search reads each stored point
// once; each vertex reads its first candidate, then every stored point for the
// registered cross products and compare, and waits on result stalls. A walk
// that has not closed after 64 vertices ends with cut_short set on its last one.
`timescale 1ns / 1ps
`include "gift_wrapping_convex_hull_unit_assert.svh"
module gift_wrapping_convex_hull_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gwch_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gwch_pkg::rsp_type rsp_data
);
   import gwch_pkg::*;

   mem_wr_type mem_wr;
   idx_type    rd_addr;
   point_type  rd_data;
   push_type   push;
   logic       load_ready;
   logic       slot_free;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   gwch_point_mem u_point_mem (
      .clock   (clock),
      .mem_wr  (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gwch_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_valid && !req_stall),
      .req_data   (req_data),
      .load_ready (load_ready),
      .mem_wr     (mem_wr),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .slot_free  (slot_free),
      .push       (push)
   );

   assign req_stall = !load_ready;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push.data;
      end else if (!rsp_stall) begin
         // drop the held result once its transfer is done
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HULL_ASSERT_IMP(a_no_overwrite, push.valid && rsp_valid_ff, !rsp_stall)
   `HULL_ASSERT_IMP(a_no_load_while_busy, !load_ready, !mem_wr.en)
   `HULL_ASSERT_NEXT(a_push_shows, push.valid, rsp_valid_ff)

endmodule

FILE: rtl/gwch_point_mem.sv
// Point store: one write port, one registered read port
`timescale 1ns / 1ps
module gwch_point_mem (
   input  logic                 clock,
   input  gwch_pkg::mem_wr_type mem_wr,
   input  gwch_pkg::idx_type    rd_addr,
   output gwch_pkg::point_type  rd_data
);
   import gwch_pkg::*;

   point_type mem [MAX_POINTS];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= mem_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gwch_orient.sv
// Orientation test: registered cross products, then signed compare
`timescale 1ns / 1ps
module gwch_orient (
   input  logic                clock,
   input  gwch_pkg::point_type cur_pt,
   input  gwch_pkg::point_type test_pt,
   input  gwch_pkg::point_type cand_pt,
   output logic                ccw
);
   import gwch_pkg::*;

   logic signed [DIFF_BITS-1:0] dy_tc;
   logic signed [DIFF_BITS-1:0] dx_rt;
   logic signed [DIFF_BITS-1:0] dx_tc;
   logic signed [DIFF_BITS-1:0] dy_rt;
   logic signed [PROD_BITS-1:0] p1_in;
   logic signed [PROD_BITS-1:0] p2_in;
   logic signed [PROD_BITS-1:0] p1_ff;
   logic signed [PROD_BITS-1:0] p2_ff;

   assign dy_tc = DIFF_BITS'(test_pt.y) - DIFF_BITS'(cur_pt.y);
   assign dx_rt = DIFF_BITS'(cand_pt.x) - DIFF_BITS'(test_pt.x);
   assign dx_tc = DIFF_BITS'(test_pt.x) - DIFF_BITS'(cur_pt.x);
   assign dy_rt = DIFF_BITS'(cand_pt.y) - DIFF_BITS'(test_pt.y);

   // Products are exact at this width: differences are one bit wider than a coordinate.
   assign p1_in = PROD_BITS'(dy_tc) * PROD_BITS'(dx_rt);
   assign p2_in = PROD_BITS'(dx_tc) * PROD_BITS'(dy_rt);

   always_ff @(posedge clock) begin
      p1_ff <= p1_in;
      p2_ff <= p2_in;
   end

   assign ccw = (p1_ff < p2_ff);

endmodule

FILE: rtl/gwch_seq.sv
// Load, start search and hull walk sequencer around the point store
`timescale 1ns / 1ps
`include "gift_wrapping_convex_hull_unit_assert.svh"
module gwch_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  gwch_pkg::req_type    req_data,
   output logic                 load_ready,
   output gwch_pkg::mem_wr_type mem_wr,
   output gwch_pkg::idx_type    rd_addr,
   input  gwch_pkg::point_type  rd_data,
   input  logic                 slot_free,
   output gwch_pkg::push_type   push
);
   import gwch_pkg::*;

   typedef enum logic [6:0] {
      ST_LOAD     = 7'b0000001,
      ST_FIND     = 7'b0000010,
      ST_CAND_RD  = 7'b0000100,
      ST_CAND_LD  = 7'b0001000,
      ST_SCAN_MUL = 7'b0010000,
      ST_SCAN_CMP = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   cnt_type   cnt_ff, cnt_in;
   cnt_type   idx_ff, idx_in;
   cnt_type   emit_ff, emit_in;
   idx_type   start_ff, start_in;
   idx_type   cur_ff, cur_in;
   idx_type   cand_ff, cand_in;
   point_type cur_pt_ff, cur_pt_in;
   point_type cand_pt_ff, cand_pt_in;
   point_type test_pt_ff, test_pt_in;

   cnt_type   idx_inc;
   cnt_type   idx_dec;
   cnt_type   cur_inc;
   logic      ccw;
   logic      back;
   logic      last;

   gwch_orient u_orient (
      .clock   (clock),
      .cur_pt  (cur_pt_ff),
      .test_pt (rd_data),
      .cand_pt (cand_pt_ff),
      .ccw     (ccw)
   );

   assign idx_inc = idx_ff + 1'b1;
   assign idx_dec = idx_ff - 1'b1;
   assign cur_inc = {1'b0, cur_ff} + 1'b1;
   assign back    = (cand_ff == start_ff);
   assign last    = back || (emit_ff == CNT_BITS'(MAX_POINTS - 1));

   assign load_ready = (state_ff == ST_LOAD);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      emit_in    = emit_ff;
      start_in   = start_ff;
      cur_in     = cur_ff;
      cand_in    = cand_ff;
      cur_pt_in  = cur_pt_ff;
      cand_pt_in = cand_pt_ff;
      test_pt_in = test_pt_ff;
      rd_addr    = '0;
      mem_wr.en   = 1'b0;
      mem_wr.addr = cnt_ff[IDX_BITS-1:0];
      mem_wr.data = '{x: req_data.px, y: req_data.py};
      push.valid = 1'b0;
      push.data  = '{hull_x: cur_pt_ff.x, hull_y: cur_pt_ff.y,
                     final_vertex: last, cut_short: last && !back};

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               // drop points beyond a full store
               if (cnt_ff < CNT_BITS'(MAX_POINTS)) begin
                  mem_wr.en = 1'b1;
                  cnt_in    = cnt_ff + 1'b1;
               end
               if (req_data.final_point) begin
                  idx_in   = '0;
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            // read index idx while the data of idx-1 arrives
            rd_addr = idx_ff[IDX_BITS-1:0];
            if (idx_ff != '0) begin
               if (idx_ff == CNT_BITS'(1) || rd_data.x < cur_pt_ff.x) begin
                  start_in  = idx_dec[IDX_BITS-1:0];
                  cur_in    = idx_dec[IDX_BITS-1:0];
                  cur_pt_in = rd_data;
               end
            end
            idx_in = idx_inc;
            if (idx_ff == cnt_ff) begin
               emit_in  = '0;
               state_in = ST_CAND_RD;
            end
         end
         ST_CAND_RD: begin
            rd_addr  = (cur_inc == cnt_ff) ? '0 : cur_inc[IDX_BITS-1:0];
            cand_in  = rd_addr;
            state_in = ST_CAND_LD;
         end
         ST_CAND_LD: begin
            cand_pt_in = rd_data;
            rd_addr    = '0;
            idx_in     = '0;
            state_in   = ST_SCAN_MUL;
         end
         ST_SCAN_MUL: begin
            // products settle into the orientation unit; prefetch the next point
            test_pt_in = rd_data;
            rd_addr    = idx_inc[IDX_BITS-1:0];
            state_in   = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            rd_addr = idx_inc[IDX_BITS-1:0];
            if (ccw) begin
               cand_in    = idx_ff[IDX_BITS-1:0];
               cand_pt_in = test_pt_ff;
            end
            idx_in   = idx_inc;
            state_in = (idx_inc == cnt_ff) ? ST_EMIT : ST_SCAN_MUL;
         end
         ST_EMIT: begin
            if (slot_free) begin
               push.valid = 1'b1;
               emit_in    = emit_ff + 1'b1;
               if (last) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  cur_in    = cand_ff;
                  cur_pt_in = cand_pt_ff;
                  state_in  = ST_CAND_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         emit_ff  <= '0;
         start_ff <= '0;
         cur_ff   <= '0;
         cand_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         emit_ff  <= emit_in;
         start_ff <= start_in;
         cur_ff   <= cur_in;
         cand_ff  <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_pt_ff  <= cur_pt_in;
      cand_pt_ff <= cand_pt_in;
      test_pt_ff <= test_pt_in;
   end

   `HULL_ASSERT_IMP(a_wr_only_in_load, mem_wr.en, state_ff == ST_LOAD)
   `HULL_ASSERT_IMP(a_cand_in_set, state_ff == ST_SCAN_CMP, {1'b0, cand_ff} < cnt_ff)
   `HULL_ASSERT_IMP(a_cut_at_limit, push.valid && push.data.cut_short, push.data.final_vertex && emit_ff == CNT_BITS'(MAX_POINTS - 1))
   `HULL_ASSERT_NEXT(a_final_clears_set, push.valid && push.data.final_vertex, state_ff == ST_LOAD && cnt_ff == '0)

endmodule

FILE: tb/sv/tb.sv
// Testbench for the gift wrapping convex hull unit: point-set stimulus, hull prediction, checks
`timescale 1ns / 1ps
module tb;
   import gwch_pkg::*;

   localparam int SET_POINTS  = 320;
   localparam int CALM_POINTS = 40;
   localparam int QUIET_LIMIT = 5000;
   localparam int TAIL_CYCLES = 300;

   typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_EXTREME} spread_type;

   typedef struct {
      req_type data;
      bit      drain;
   } point_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   point_item_type pending_points[$];
   rsp_type        hull_expect[$];

   // predictor copy of the point store
   longint store_x[MAX_POINTS];
   longint store_y[MAX_POINTS];
   int     stored_count = 0;

   int  points_queued = 0;
   int  points_sent = 0;
   int  sets_sent = 0;
   int  vertices_checked = 0;
   int  walks_cut = 0;
   int  errors = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;

   gift_wrapping_convex_hull_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // true when point b lies strictly clockwise of candidate r as seen from c
   function automatic bit beats_candidate(int c, int b, int r);
      longint lhs;
      longint rhs;
      lhs = (store_y[b] - store_y[c]) * (store_x[r] - store_x[b]);
      rhs = (store_x[b] - store_x[c]) * (store_y[r] - store_y[b]);
      return lhs < rhs;
   endfunction

   function automatic void walk_hull();
      int      n;
      int      first;
      int      cur;
      int      cand;
      int      emitted;
      int      i;
      bit      closed;
      rsp_type vertex;
      n = stored_count;
      first = 0;
      for (i = 1; i < n; i++)
         if (store_x[i] < store_x[first]) first = i;
      cur = first;
      emitted = 0;
      closed = 1'b0;
      while (emitted < MAX_POINTS && !closed) begin
         vertex = '0;
         vertex.hull_x = coord_type'(store_x[cur]);
         vertex.hull_y = coord_type'(store_y[cur]);
         hull_expect = {hull_expect, vertex};
         emitted++;
         cand = (cur + 1) % n;
         for (i = 0; i < n; i++)
            if (beats_candidate(cur, i, cand)) cand = i;
         cur = cand;
         closed = (cur == first);
      end
      vertex = hull_expect.pop_back();
      vertex.final_vertex = 1'b1;
      vertex.cut_short = !closed;
      hull_expect = {hull_expect, vertex};
      stored_count = 0;
   endfunction

   function automatic void load_point(req_type d);
      if (stored_count < MAX_POINTS) begin
         store_x[stored_count] = longint'($signed(d.px));
         store_y[stored_count] = longint'($signed(d.py));
         stored_count++;
      end
      if (d.final_point) begin
         walk_hull();
         sets_sent++;
      end
   endfunction

   function automatic void add_point(int x, int y, bit last, bit drain);
      point_item_type item;
      item.data.px = coord_type'(x);
      item.data.py = coord_type'(y);
      item.data.final_point = last;
      item.drain = drain;
      pending_points = {pending_points, item};
      points_queued++;
   endfunction

   function automatic int rand_coord(spread_type spread);
      int v;
      case (spread)
         SPREAD_CLUSTER: v = int'($urandom_range(0, 6)) - 3;
         SPREAD_EXTREME: begin
            case ($urandom_range(0, 4))
               0: v = -32768;
               1: v = -1;
               2: v = 0;
               3: v = 1;
               default: v = 32767;
            endcase
         end
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      return v;
   endfunction

   function automatic void add_random_set(int size, spread_type spread, bit drain);
      int k;
      for (k = 0; k < size; k++)
         add_point(rand_coord(spread), rand_coord(spread), k == size - 1, drain && k == 0);
   endfunction

   // sender: present queued points, idle in short bursts, predict on each transfer
   always @(posedge clock) begin
      point_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            load_point(req_data);
            points_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_points.size() > 0 &&
                         !(pending_points[0].drain && hull_expect.size() > 0)) begin
               item = pending_points.pop_front();
               req_valid <= 1'b1;
               req_data  <= item.data;
               if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
         calm <= pending_points.size() < CALM_POINTS;
      end
   end

   // receiver: check each result transfer against the oldest expected vertex
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hull_expect.size() == 0) begin
               $error("hull vertex (%0d, %0d) arrived with none expected",
                      rsp_data.hull_x, rsp_data.hull_y);
               errors++;
            end else begin
               want = hull_expect.pop_front();
               if (rsp_data.hull_x !== want.hull_x) begin
                  $error("hull_x mismatch: expected %0d, got %0d",
                         want.hull_x, rsp_data.hull_x);
                  errors++;
               end
               if (rsp_data.hull_y !== want.hull_y) begin
                  $error("hull_y mismatch: expected %0d, got %0d",
                         want.hull_y, rsp_data.hull_y);
                  errors++;
               end
               if (rsp_data.final_vertex !== want.final_vertex) begin
                  $error("final_vertex mismatch: expected %0b, got %0b",
                         want.final_vertex, rsp_data.final_vertex);
                  errors++;
               end
               if (rsp_data.cut_short !== want.cut_short) begin
                  $error("cut_short mismatch: expected %0b, got %0b",
                         want.cut_short, rsp_data.cut_short);
                  errors++;
               end
               vertices_checked++;
               if (want.cut_short) walks_cut++;
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("gift_wrapping_convex_hull_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int size;
      // single point, sent after a full drain
      add_point(32767, -32768, 1'b1, 1'b1);
      add_point(-32768, 32767, 1'b0, 1'b0);
      add_point(32767, -32768, 1'b1, 1'b0);
      // extreme corners with an interior point
      add_point(-32768, -32768, 1'b0, 1'b1);
      add_point(32767, -32768, 1'b0, 1'b0);
      add_point(32767, 32767, 1'b0, 1'b0);
      add_point(-32768, 32767, 1'b0, 1'b0);
      add_point(0, 0, 1'b1, 1'b0);
      // duplicate of the start point traps the walk until the vertex limit
      add_point(0, 0, 1'b0, 1'b0);
      add_point(1, 1, 1'b0, 1'b0);
      add_point(0, 0, 1'b0, 1'b0);
      add_point(1, -1, 1'b1, 1'b0);
      // collinear points
      add_point(5, 5, 1'b0, 1'b0);
      add_point(1, 1, 1'b0, 1'b0);
      add_point(3, 3, 1'b0, 1'b0);
      add_point(-2, -2, 1'b0, 1'b0);
      add_point(7, 7, 1'b1, 1'b0);
      // all points identical
      repeat (3) add_point(-7, 9, 1'b0, 1'b0);
      add_point(-7, 9, 1'b1, 1'b0);
      // overflow the store: trailing points are dropped, the final mark still runs the hull
      add_random_set(MAX_POINTS + 6, spread_type'($urandom_range(0, 2)), 1'b1);
      while (points_queued < SET_POINTS) begin
         if ($urandom_range(0, 14) == 0) size = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 6);
         else size = $urandom_range(1, 12);
         if (size > SET_POINTS - points_queued) size = SET_POINTS - points_queued;
         add_random_set(size, spread_type'($urandom_range(0, 2)), $urandom_range(0, 5) == 0);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (points_sent < points_queued || hull_expect.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d points in %0d sets, including store overflow and trapped walks.",
               points_sent, sets_sent);
      $display("Checked %0d hull vertices, %0d of them ending a walk cut short.",
               vertices_checked, walks_cut);
      if (errors == 0 && hull_expect.size() == 0) begin
         $display("gift_wrapping_convex_hull_unit verification clean");
      end else begin
         $display("gift_wrapping_convex_hull_unit verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/gwch_pkg.sv
rtl/gwch_point_mem.sv
rtl/gwch_orient.sv
rtl/gwch_seq.sv
rtl/gift_wrapping_convex_hull_unit.sv
tb/sv/tb.sv
